// ----- sv/wsu_pkg.sv -----
// ----------------------------------------------------------------------------
// wsu_pkg
// Shared types and constants for the frame unmasker: result record and
// result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wsu_pkg;

  localparam logic [7:0] CLOSE_BYTE = 8'h88;
  localparam logic [6:0] LEN_MASK   = 7'h7F;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_CLOSE   = 1'b1
  } wsu_kind_t;

  // One result as produced by the parser for the item in the input register.
  typedef struct packed {
    logic       present;
    logic [7:0] data;
    logic       last;
    wsu_kind_t  kind;
  } wsu_res_t;

endpackage

`default_nettype wire

// ----- sv/wsu_in_stage.sv -----
// ----------------------------------------------------------------------------
// wsu_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsu_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       take_i,
  output logic            vld_o,
  output logic [7:0]      byte_o
);
  import wsu_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // A new item may enter whenever the held one leaves in the same cycle.
  assign in_ready = !vld_r || take_i;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign vld_o  = vld_r;
  assign byte_o = byte_r;

endmodule

`default_nettype wire

// ----- sv/wsu_parser.sv -----
// ----------------------------------------------------------------------------
// wsu_parser
// Frame state machine: tracks header, key and payload bytes, keeps the
// masking key and forms the result for the current byte: unmasked payload or close.
// ----------------------------------------------------------------------------
`default_nettype none

module wsu_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            step_i,
  output wsu_pkg::wsu_res_t    res_o
);
  import wsu_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_KEY     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CLOSED  = 3'd4
  } phase_t;

  phase_t     phase_r,    phase_nxt;
  logic [6:0] left_r,     left_nxt;
  logic [1:0] kpos_r,     kpos_nxt;
  logic [7:0] key_r [4];
  wsu_res_t   res;

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    kpos_nxt    = kpos_r;
    res.present = 1'b0;
    res.data    = 8'h00;
    res.last    = 1'b0;
    res.kind    = KIND_PAYLOAD;
    case (phase_r)
      PH_HDR1: begin
        left_nxt  = byte_i[6:0] & LEN_MASK;
        kpos_nxt  = 2'd0;
        phase_nxt = PH_KEY;
      end
      PH_KEY: begin
        kpos_nxt = kpos_r + 2'd1;
        if (kpos_r == 2'd3) begin
          phase_nxt = (left_r == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        kpos_nxt    = kpos_r + 2'd1;
        left_nxt    = left_r - 7'd1;
        res.present = vld_i;
        res.data    = byte_i ^ key_r[kpos_r];
        res.last    = (left_r == 7'd1);
        if (left_r == 7'd1) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_CLOSED: begin
        phase_nxt = PH_CLOSED;
      end
      default: begin
        if (byte_i == CLOSE_BYTE) begin
          res.present = vld_i;
          res.kind    = KIND_CLOSE;
          phase_nxt   = PH_CLOSED;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      left_r  <= 7'd0;
      kpos_r  <= 2'd0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      kpos_r  <= kpos_nxt;
    end
  end

  // Key bytes are always written before the first payload byte reads them.
  always_ff @(posedge clk) begin
    if (step_i && phase_r == PH_KEY) begin
      key_r[kpos_r] <= byte_i;
    end
  end

  assign res_o = res;

`ifndef SYNTH
  a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLOSED |=> phase_r == PH_CLOSED)
    else $error("parser left the closed phase");

  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLOSED |-> !res.present)
    else $error("result produced after close");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 7'd0)
    else $error("payload phase with no bytes left");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res.present && res.last |=> phase_r == PH_HDR0)
    else $error("last payload byte did not return to header phase");
`endif

endmodule

`default_nettype wire

// ----- sv/wsu_out_stage.sv -----
// ----------------------------------------------------------------------------
// wsu_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsu_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_i,
  input  wire wsu_pkg::wsu_res_t res_i,
  output logic                   space_o,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_of_frame,
  output logic                   out_result_kind
);
  import wsu_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  wsu_res_t res_r;

  // The register can take a new result when empty or emptied this cycle.
  assign space_o = !vld_r || out_ready;
  assign vld_nxt = load_i ? 1'b1 : (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid         = vld_r;
  assign out_byte          = res_r.data;
  assign out_last_of_frame = res_r.last;
  assign out_result_kind   = res_r.kind;

endmodule

`default_nettype wire

// ----- sv/websocket_frame_unmasker.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Unmasks a byte stream of back-to-back client frames; reports a close frame
// once and then drops all further input until reset.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid/in_ready     in_byte[7:0]
//   out_      output     out_valid/out_ready   out_byte[7:0], out_last_of_frame,
//                                              out_result_kind
//
// One byte is accepted per cycle while the input register is empty or its
// held byte moves on; the byte's result is loaded into the result register
// as it moves on. Header and key bytes, except a close byte, and every byte
// after a close, produce no result; the result register drives the outputs.
// Reset is synchronous and active low and returns the parser to the header.
// A stalled output holds its result; input keeps flowing while the held
// byte produces no result or the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_unmasker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_frame,
  output logic            out_result_kind
);
  import wsu_pkg::*;

  logic       cur_vld;
  logic [7:0] cur_byte;
  logic       space;
  logic       advance;
  wsu_res_t   res;

  // The held byte moves on unless it has a result with nowhere to go.
  assign advance = cur_vld && (!res.present || space);

  wsu_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .take_i   (advance),
    .vld_o    (cur_vld),
    .byte_o   (cur_byte)
  );

  wsu_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (cur_vld),
    .byte_i (cur_byte),
    .step_i (advance),
    .res_o  (res)
  );

  wsu_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_i            (advance && res.present),
    .res_i             (res),
    .space_o           (space),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_result_kind   (out_result_kind)
  );

endmodule

`default_nettype wire
